@@ src/i6t_pkg.sv @@
// ----------------------------------------------------------------------------
// i6t_pkg: shared types and constants for the ipv6 address text formatter
// Field widths, character codes, lane and run summaries, decimal unit status.
// ----------------------------------------------------------------------------
package i6t_pkg;

   // field widths
   localparam int FUNC_W   = 1;
   localparam int ADDR_W   = 64;
   localparam int SCOPE_W  = 32;
   localparam int PORT_W   = 16;
   localparam int TDATA_W  = 2 * ADDR_W + SCOPE_W + PORT_W;
   localparam int CHAR_W   = 8;

   // address split into quads
   localparam int QUADS    = 8;
   localparam int QUAD_W   = 16;
   localparam int NIB_W    = 4;
   localparam int NIBS     = QUAD_W / NIB_W;
   localparam int QIDX_W   = $clog2(QUADS);
   localparam int QCNT_W   = QIDX_W + 1;
   localparam int NIDX_W   = $clog2(NIBS);

   // decimal conversion
   localparam int DEC_DIGITS  = 10;
   localparam int DIDX_W      = $clog2(DEC_DIGITS);
   localparam int PROD_W      = 2 * SCOPE_W;
   localparam int RECIP_SHIFT = 35;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [SCOPE_W-1:0] RECIP_TEN = 32'hcccc_cccd;

   // thresholds for the number of hex digits in a quad
   localparam logic [QUAD_W-1:0] HEX4_MIN = 16'h1000;
   localparam logic [QUAD_W-1:0] HEX3_MIN = 16'h0100;
   localparam logic [QUAD_W-1:0] HEX2_MIN = 16'h0010;

   // character codes
   localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5b;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5d;
   localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

   // hex digits, written high to low so that entry n is digit n
   localparam logic [15:0][CHAR_W-1:0] HEX_TAB = "fedcba9876543210";

   // one lane's view of its quad
   typedef struct packed {
      logic                         zero;
      logic [NIDX_W-1:0]            top;
      logic [NIBS-1:0][CHAR_W-1:0]  chars;
   } lane_type;

   // longest zero run found over the lanes
   typedef struct packed {
      logic              found;
      logic [QIDX_W-1:0] start;
      logic [QCNT_W-1:0] len;
   } run_type;

   // decimal unit status and read data
   typedef struct packed {
      logic              busy;
      logic [DIDX_W-1:0] count;
      logic [NIB_W-1:0]  digit;
   } dec_status_type;

endpackage

@@ src/i6t_lane.sv @@
// ----------------------------------------------------------------------------
// i6t_lane: per-quad hex lane
// Flags a zero quad, finds its leading digit and gives the hex characters.
// ----------------------------------------------------------------------------
module i6t_lane (
   input  logic [i6t_pkg::QUAD_W-1:0] quad,
   output i6t_pkg::lane_type          lane
);

   always_comb begin
      lane.zero = (quad == '0);

      // position of the most significant digit that is printed
      if (quad >= i6t_pkg::HEX4_MIN) begin
         lane.top = i6t_pkg::NIDX_W'(3);
      end else if (quad >= i6t_pkg::HEX3_MIN) begin
         lane.top = i6t_pkg::NIDX_W'(2);
      end else if (quad >= i6t_pkg::HEX2_MIN) begin
         lane.top = i6t_pkg::NIDX_W'(1);
      end else begin
         lane.top = '0;
      end

      // one character per nibble
      for (int n = 0; n < i6t_pkg::NIBS; n++) begin
         lane.chars[n] = i6t_pkg::HEX_TAB[quad[n*i6t_pkg::NIB_W +: i6t_pkg::NIB_W]];
      end
   end

endmodule

@@ src/i6t_merge.sv @@
// ----------------------------------------------------------------------------
// i6t_merge: zero run merge
// Finds the leftmost longest run of two or more zero quads in the lane flags.
// ----------------------------------------------------------------------------
module i6t_merge (
   input  logic [i6t_pkg::QUADS-1:0] zero,
   output i6t_pkg::run_type          run
);

   logic [i6t_pkg::QCNT_W-1:0] cur;
   logic [i6t_pkg::QCNT_W-1:0] best_len;
   logic [i6t_pkg::QCNT_W-1:0] first;
   logic [i6t_pkg::QIDX_W-1:0] best_start;
   logic                       found;

   // scan left to right, only a strictly longer run replaces the best
   always_comb begin
      cur        = '0;
      best_len   = i6t_pkg::QCNT_W'(1);
      best_start = '0;
      first      = '0;
      found      = 1'b0;
      for (int i = 0; i < i6t_pkg::QUADS; i++) begin
         if (!zero[i]) begin
            cur = '0;
         end else begin
            cur = cur + i6t_pkg::QCNT_W'(1);
            if (cur > best_len) begin
               best_len   = cur;
               first      = i6t_pkg::QCNT_W'(i) + i6t_pkg::QCNT_W'(1) - cur;
               best_start = first[i6t_pkg::QIDX_W-1:0];
               found      = 1'b1;
            end
         end
      end
      run.found = found;
      run.start = best_start;
      run.len   = best_len;
   end

endmodule

@@ src/i6t_dec.sv @@
// ----------------------------------------------------------------------------
// i6t_dec: decimal digit unit
// Converts a 32-bit value to decimal, one digit per multiply and split step, by
// multiplying with the reciprocal of ten. Digits are kept least significant
// first and read back at one index.
// ----------------------------------------------------------------------------
module i6t_dec (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [i6t_pkg::SCOPE_W-1:0]  value,
   input  logic [i6t_pkg::DIDX_W-1:0]   rd_idx,
   output i6t_pkg::dec_status_type      status
);

   logic [i6t_pkg::SCOPE_W-1:0] val_ff, val_in;
   logic [i6t_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                        phase_ff, phase_in;
   logic                        busy_ff, busy_in;
   logic [i6t_pkg::DIDX_W-1:0]  cnt_ff, cnt_in;
   logic [i6t_pkg::NIB_W-1:0]   digit_ff [i6t_pkg::DEC_DIGITS];
   logic [i6t_pkg::QUOT_W-1:0]  quot;
   logic [i6t_pkg::NIB_W-1:0]   quot_ten;
   logic [i6t_pkg::NIB_W-1:0]   rem;

   // quotient from the product, remainder from the low bits only
   assign quot     = prod_ff[i6t_pkg::PROD_W-1:i6t_pkg::RECIP_SHIFT];
   assign quot_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
   assign rem      = val_ff[i6t_pkg::NIB_W-1:0] - quot_ten;

   // two-phase step: multiply, then split off one digit
   always_comb begin
      val_in   = val_ff;
      prod_in  = prod_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         val_in   = value;
         phase_in = 1'b0;
         busy_in  = 1'b1;
         cnt_in   = '0;
      end else if (busy_ff && !phase_ff) begin
         prod_in  = i6t_pkg::PROD_W'(val_ff) * i6t_pkg::PROD_W'(i6t_pkg::RECIP_TEN);
         phase_in = 1'b1;
      end else if (busy_ff) begin
         val_in   = i6t_pkg::SCOPE_W'(quot);
         phase_in = 1'b0;
         cnt_in   = cnt_ff + i6t_pkg::DIDX_W'(1);
         busy_in  = (quot != '0);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   // working value and product
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      prod_ff <= prod_in;
   end

   // digit store
   always_ff @(posedge clock) begin
      if (busy_ff && phase_ff && !start) begin
         digit_ff[cnt_ff] <= rem;
      end
   end

   assign status.busy  = busy_ff;
   assign status.count = cnt_ff;
   assign status.digit = digit_ff[rd_idx];

endmodule

@@ src/ipv6_address_to_text_core.sv @@
// ----------------------------------------------------------------------------
// ipv6_address_to_text_core: ipv6 address to text formatter
// Writes an address as compressed lowercase hex text, optionally wrapped as
// [addr%scope]:port, one character per result transaction.
//
//   channel | dir | tdata                                   | tuser | tlast
//   req     | in  | addr_high, addr_low, scope_id, port_num | func  | -
//   rsp     | out | text_char                               | -     | last_char
//
// - one transaction at a time: accept, a load state, then one character per
//   cycle when rsp does not stall, apart from waits on the decimal unit
// - decimal digits come from a shared divide-by-ten unit; scope conversion
//   runs under the address text, the port conversion starts at the closing
//   bracket, so the bracketed form waits for the port digits, and for the
//   scope digits too when the address text is short
// - req_tready is high only while idle; the next address is taken while the
//   last character still sits in the output register
// - a stalled rsp_tready holds the output register and each character state
// - synchronous active-high reset returns to idle with no output pending
// ----------------------------------------------------------------------------
module ipv6_address_to_text_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // addr_high, addr_low, scope_id, port_number
   input  logic [i6t_pkg::TDATA_W-1:0]  req_tdata,
   // func
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // text_char
   output logic [i6t_pkg::CHAR_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_LOAD  = 4'd1;
   localparam logic [ST_W-1:0] ST_OPEN  = 4'd2;
   localparam logic [ST_W-1:0] ST_RUN   = 4'd3;
   localparam logic [ST_W-1:0] ST_COLON = 4'd4;
   localparam logic [ST_W-1:0] ST_HEX   = 4'd5;
   localparam logic [ST_W-1:0] ST_PCT   = 4'd6;
   localparam logic [ST_W-1:0] ST_SCOPE = 4'd7;
   localparam logic [ST_W-1:0] ST_CLOSE = 4'd8;
   localparam logic [ST_W-1:0] ST_SEP   = 4'd9;
   localparam logic [ST_W-1:0] ST_PORT  = 4'd10;

   logic [ST_W-1:0]                              state_ff, state_in;
   logic                                         func_ff;
   logic [i6t_pkg::QUADS-1:0][i6t_pkg::QUAD_W-1:0] quad_ff, quad_in;
   logic [i6t_pkg::SCOPE_W-1:0]                  scope_ff;
   logic [i6t_pkg::PORT_W-1:0]                   port_ff;
   logic [i6t_pkg::QCNT_W-1:0]                   qi_ff, qi_in;
   logic                                         sub_ff, sub_in;
   logic [i6t_pkg::NIDX_W-1:0]                   dig_ff, dig_in;
   logic [i6t_pkg::DIDX_W-1:0]                   pos_ff, pos_in;
   logic                                         rsp_valid_ff;
   logic [i6t_pkg::CHAR_W-1:0]                   rsp_data_ff;
   logic                                         rsp_last_ff;

   i6t_pkg::lane_type                            lanes [i6t_pkg::QUADS];
   logic [i6t_pkg::QUADS-1:0]                    zero_vec;
   i6t_pkg::run_type                             run;
   i6t_pkg::dec_status_type                      dec;
   logic [i6t_pkg::DIDX_W-1:0]                   dec_idx;
   logic [i6t_pkg::DIDX_W-1:0]                   dec_last;
   logic                                         dec_start;
   logic [i6t_pkg::SCOPE_W-1:0]                  dec_value;

   logic                                         accept;
   logic                                         out_load;
   logic                                         ch_valid;
   logic                                         ch_emit;
   logic [i6t_pkg::CHAR_W-1:0]                   ch_data;
   logic                                         ch_last;
   logic                                         step_done;
   logic                                         after_hex;
   logic [i6t_pkg::QCNT_W-1:0]                   nq;

   // input handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // split the address into quads, quad 0 at the top of addr_high
   always_comb begin
      for (int i = 0; i < i6t_pkg::QUADS / 2; i++) begin
         quad_in[i] = req_tdata[i6t_pkg::ADDR_W - 1 - i*i6t_pkg::QUAD_W -: i6t_pkg::QUAD_W];
         quad_in[i + i6t_pkg::QUADS/2] =
            req_tdata[2*i6t_pkg::ADDR_W - 1 - i*i6t_pkg::QUAD_W -: i6t_pkg::QUAD_W];
      end
   end

   // captured transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_tuser;
         quad_ff  <= quad_in;
         scope_ff <= req_tdata[2*i6t_pkg::ADDR_W +: i6t_pkg::SCOPE_W];
         port_ff  <= req_tdata[2*i6t_pkg::ADDR_W + i6t_pkg::SCOPE_W +: i6t_pkg::PORT_W];
      end
   end

   // hex lanes, one per quad
   for (genvar g = 0; g < i6t_pkg::QUADS; g++) begin : g_lane
      i6t_lane u_lane (
         .quad (quad_ff[g]),
         .lane (lanes[g])
      );
      assign zero_vec[g] = lanes[g].zero;
   end

   // longest zero run over the lanes
   i6t_merge u_merge (
      .zero (zero_vec),
      .run  (run)
   );

   // shared decimal unit, digits read most significant first
   assign dec_last = dec.count - i6t_pkg::DIDX_W'(1);
   assign dec_idx  = dec_last - pos_ff;

   i6t_dec u_dec (
      .clock  (clock),
      .reset  (reset),
      .start  (dec_start),
      .value  (dec_value),
      .rd_idx (dec_idx),
      .status (dec)
   );

   // output register takes a character when empty or being drained
   assign out_load = !rsp_valid_ff || rsp_tready;
   assign ch_emit  = ch_valid && out_load;

   // character sequencer
   always_comb begin
      state_in  = state_ff;
      qi_in     = qi_ff;
      sub_in    = sub_ff;
      dig_in    = dig_ff;
      pos_in    = pos_ff;
      ch_valid  = 1'b0;
      ch_data   = i6t_pkg::CH_COLON;
      ch_last   = 1'b0;
      dec_start = 1'b0;
      dec_value = scope_ff;
      nq        = '0;
      after_hex = 1'b0;
      step_done = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            dec_start = func_ff && (scope_ff != '0);
            if (func_ff) begin
               state_in = ST_OPEN;
            end else begin
               step_done = 1'b1;
            end
         end
         ST_OPEN: begin
            ch_valid  = 1'b1;
            ch_data   = i6t_pkg::CH_OPEN;
            step_done = out_load;
         end
         ST_RUN: begin
            // the two colons of a compressed run
            ch_valid = 1'b1;
            nq       = qi_ff + run.len;
            ch_last  = sub_ff && !func_ff && nq[i6t_pkg::QIDX_W];
            if (out_load) begin
               if (!sub_ff) begin
                  sub_in = 1'b1;
               end else begin
                  sub_in    = 1'b0;
                  step_done = 1'b1;
               end
            end
         end
         ST_COLON: begin
            ch_valid = 1'b1;
            if (out_load) begin
               state_in = ST_HEX;
               dig_in   = lanes[qi_ff[i6t_pkg::QIDX_W-1:0]].top;
            end
         end
         ST_HEX: begin
            ch_valid  = 1'b1;
            ch_data   = lanes[qi_ff[i6t_pkg::QIDX_W-1:0]].chars[dig_ff];
            nq        = qi_ff + i6t_pkg::QCNT_W'(1);
            after_hex = 1'b1;
            ch_last   = (dig_ff == '0) && !func_ff && nq[i6t_pkg::QIDX_W];
            if (out_load) begin
               if (dig_ff == '0) begin
                  step_done = 1'b1;
               end else begin
                  dig_in = dig_ff - i6t_pkg::NIDX_W'(1);
               end
            end
         end
         ST_PCT: begin
            ch_valid = 1'b1;
            ch_data  = i6t_pkg::CH_PCT;
            if (out_load) begin
               state_in = ST_SCOPE;
               pos_in   = '0;
            end
         end
         ST_SCOPE: begin
            ch_valid = !dec.busy;
            ch_data  = i6t_pkg::CH_ZERO + i6t_pkg::CHAR_W'(dec.digit);
            if (ch_valid && out_load) begin
               if (pos_ff == dec_last) begin
                  state_in = ST_CLOSE;
               end else begin
                  pos_in = pos_ff + i6t_pkg::DIDX_W'(1);
               end
            end
         end
         ST_CLOSE: begin
            ch_valid  = !dec.busy;
            ch_data   = i6t_pkg::CH_CLOSE;
            dec_value = i6t_pkg::SCOPE_W'(port_ff);
            if (ch_valid && out_load) begin
               dec_start = 1'b1;
               state_in  = ST_SEP;
            end
         end
         ST_SEP: begin
            ch_valid = 1'b1;
            if (out_load) begin
               state_in = ST_PORT;
               pos_in   = '0;
            end
         end
         ST_PORT: begin
            ch_valid = !dec.busy;
            ch_data  = i6t_pkg::CH_ZERO + i6t_pkg::CHAR_W'(dec.digit);
            ch_last  = (pos_ff == dec_last);
            if (ch_valid && out_load) begin
               if (pos_ff == dec_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + i6t_pkg::DIDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // move on to the next quad, or past the address
      if (step_done) begin
         if (nq[i6t_pkg::QIDX_W]) begin
            if (!func_ff) begin
               state_in = ST_IDLE;
            end else if (scope_ff != '0) begin
               state_in = ST_PCT;
            end else begin
               state_in = ST_CLOSE;
            end
         end else begin
            qi_in = nq;
            if (run.found && (nq[i6t_pkg::QIDX_W-1:0] == run.start)) begin
               state_in = ST_RUN;
               sub_in   = 1'b0;
            end else if (after_hex) begin
               state_in = ST_COLON;
            end else begin
               state_in = ST_HEX;
               dig_in   = lanes[nq[i6t_pkg::QIDX_W-1:0]].top;
            end
         end
      end
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         qi_ff    <= '0;
         sub_ff   <= 1'b0;
         dig_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         qi_ff    <= qi_in;
         sub_ff   <= sub_in;
         dig_ff   <= dig_in;
         pos_ff   <= pos_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= ch_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ch_emit) begin
         rsp_data_ff <= ch_data;
         rsp_last_ff <= ch_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // no conversion may be left running once the block is idle
   a_idle_dec: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !dec.busy)
      else $error("decimal unit busy while idle");

   // the final character of a transaction returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (ch_emit && ch_last) |=> req_tready)
      else $error("not idle after last character");

   // the quad walk never runs past the last quad
   a_quad_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_COLON || state_ff == ST_HEX)
         |-> !qi_ff[i6t_pkg::QIDX_W])
      else $error("quad index out of range");

   // a character is only produced while a transaction is in progress
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      ch_emit |-> !req_tready)
      else $error("character produced while idle");

endmodule
